[sv/cidf_pkg.sv]
// Shared types and constants for the CAN identifier acceptance filter.
package cidf_pkg;

	localparam int ID_W    = 11;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic    hit;
		status_t status;
	} list_result_t;

endpackage

[sv/cidf_fixed_match.sv]
// Match of an identifier against the fixed block of consecutive event identifiers.
module cidf_fixed_match #(
	parameter int FIXED_COUNT = 16
) (
	input  logic [cidf_pkg::ID_W-1:0] base_id,
	input  logic [cidf_pkg::ID_W-1:0] msg_id,
	output logic                      hit
);

	logic [cidf_pkg::ID_W-1:0] offset;

	// The range ends at the top identifier; it never wraps round to zero.
	assign offset = msg_id - base_id;
	assign hit = (msg_id >= base_id) && (offset < cidf_pkg::ID_W'(FIXED_COUNT));

endmodule

[sv/cidf_dynamic_list.sv]
// Dynamic identifier list: entry registers, parallel compare, append and shift-down removal.
module cidf_dynamic_list #(
	parameter int DEPTH = 16,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      update,
	input  logic [cidf_pkg::OP_W-1:0] opcode,
	input  logic [cidf_pkg::ID_W-1:0] msg_id,
	input  logic                      fixed_hit,
	output cidf_pkg::list_result_t    result,
	output logic [CNT_W-1:0]          count
);

	logic [cidf_pkg::ID_W-1:0] entry_q [DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic [DEPTH-1:0]          match;
	logic [DEPTH-1:0]          at_or_above;
	logic                      list_hit;
	logic                      any_hit;
	logic                      full;
	logic                      add_do;
	logic                      rem_do;
	cidf_pkg::status_t         status_d;
	logic [CNT_W-1:0]          count_d;

	for (genvar i = 0; i < DEPTH; i++) begin : g_lane
		localparam logic [DEPTH-1:0] LOW_MASK = {DEPTH{1'b1}} >> (DEPTH - 1 - i);

		assign match[i] = (CNT_W'(i) < count_q) && (entry_q[i] == msg_id);
		// Lanes at or above the matching entry move down on a removal.
		assign at_or_above[i] = |(match & LOW_MASK);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (add_do && (count_q == CNT_W'(i))) begin
				entry_q[i] <= msg_id;
			end
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			if (rem_do && at_or_above[i]) begin
				entry_q[i] <= entry_q[i + 1];
			end
		end
	end

	assign list_hit = |match;
	assign any_hit  = list_hit || fixed_hit;
	assign full     = (count_q == CNT_W'(DEPTH));

	always_comb begin
		status_d = cidf_pkg::ST_OK;
		add_do   = 1'b0;
		rem_do   = 1'b0;
		case (opcode)
			cidf_pkg::OP_ADD: begin
				if (any_hit) begin
					status_d = cidf_pkg::ST_PRESENT;
				end else if (full) begin
					status_d = cidf_pkg::ST_FULL;
				end else begin
					add_do = update;
				end
			end
			cidf_pkg::OP_REMOVE: begin
				if (!list_hit) begin
					status_d = cidf_pkg::ST_NOT_FOUND;
				end else begin
					rem_do = update;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (add_do) begin
			count_d = count_q + CNT_W'(1);
		end else if (rem_do) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign result.hit    = any_hit;
	assign result.status = status_d;
	assign count         = count_d;

endmodule

[sv/can_id_acceptance_filter_table.sv]
// Top level of the CAN identifier acceptance filter with its dynamic list.
// An item is taken into the input register and its result comes from the output register, with done high
// for a single cycle. Throughput: one item per cycle; busy stays low, since the list update
// and the compare both complete in the single stage behind the input register.
// Reset clears the list's entry count, the fixed base identifier and all valid flags; the list
// entries themselves are not cleared and are read only where they were written.
module can_id_acceptance_filter_table #(
	parameter int DYNAMIC_DEPTH = 16,
	parameter int FIXED_COUNT   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [cidf_pkg::OP_W-1:0]    opcode,
	input  logic [cidf_pkg::ID_W-1:0]    msg_id,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cidf_pkg::ID_W-1:0]    cfg_data,
	output logic                         done,
	output logic                         accepted,
	output logic [1:0]                   status,
	output logic [cidf_pkg::COUNT_W-1:0] entry_count
);

	localparam int CNT_W = $clog2(DYNAMIC_DEPTH + 1);

	logic                         valid_s1;
	logic [cidf_pkg::OP_W-1:0]    opcode_s1;
	logic [cidf_pkg::ID_W-1:0]    msg_id_s1;
	logic [cidf_pkg::ID_W-1:0]    fixed_base_q;
	logic                         fixed_hit;
	cidf_pkg::list_result_t       list_result;
	logic [CNT_W-1:0]             list_count;
	logic [CNT_W+cidf_pkg::COUNT_W-1:0] count_ext;
	logic                         done_q;
	logic                         accepted_q;
	cidf_pkg::status_t            status_q;
	logic [cidf_pkg::COUNT_W-1:0] entry_count_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			fixed_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			opcode_s1 <= opcode;
			msg_id_s1 <= msg_id;
		end
	end

	cidf_fixed_match #(
		.FIXED_COUNT(FIXED_COUNT)
	) u_fixed (
		.base_id(fixed_base_q),
		.msg_id (msg_id_s1),
		.hit    (fixed_hit)
	);

	cidf_dynamic_list #(
		.DEPTH(DYNAMIC_DEPTH)
	) u_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (valid_s1),
		.opcode   (opcode_s1),
		.msg_id   (msg_id_s1),
		.fixed_hit(fixed_hit),
		.result   (list_result),
		.count    (list_count)
	);

	// The count port keeps only its low bits when the list is deeper than it can show.
	assign count_ext = {{cidf_pkg::COUNT_W{1'b0}}, list_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			accepted_q    <= list_result.hit;
			status_q      <= list_result.status;
			entry_count_q <= count_ext[cidf_pkg::COUNT_W-1:0];
		end
	end

	assign done        = done_q;
	assign accepted    = accepted_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

[sv/cidf_checker.sv]
// Port-level checks for the CAN identifier acceptance filter, bound to the top level.
module cidf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       accepted,
	input logic [1:0] status
);

	// Every item taken is followed by a done strobe.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("item taken but no result two cycles later");

	// No result appears without an item taken before it.
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result strobe without a matching item");

	// An identifier reported as already present must be accepted.
	a_present_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cidf_pkg::ST_PRESENT) |-> accepted)
		else $error("already-present status on an identifier that is not accepted");

	// A full list is only reported for an identifier that is not accepted.
	a_full_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cidf_pkg::ST_FULL) |-> !accepted)
		else $error("list-full status on an accepted identifier");

endmodule

bind can_id_acceptance_filter_table cidf_checker u_cidf_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.accepted(accepted),
	.status  (status)
);
